// ===== hdl/csb_pkg.sv =====
// Shared types and constants for the clipped sprite blitter.
// Holds the payload words, configuration indexes, controller states and
// the command and status groups that join the controller and the datapath.
package csb_pkg;

   // Field widths of the words on the channels.
   localparam int COORD_BITS = 12;
   localparam int ADDR_BITS  = 20;
   localparam int DIM_BITS   = 11;
   localparam int COLOR_BITS = 8;
   localparam int FADE_BITS  = 8;

   // Internal widths: clipped coordinates and linear offsets.
   localparam int CALC_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 4;
   localparam int OFF_BITS  = CALC_BITS + 14;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BITMAP_WIDTH  = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BITMAP_HEIGHT = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_KEY     = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSLATE_X   = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRANSLATE_Y   = CSR_INDEX_BITS'(6);

   // Register values after reset.
   localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RESET   = DIM_BITS'(320);
   localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RESET  = DIM_BITS'(240);
   localparam logic [DIM_BITS-1:0]   BITMAP_WIDTH_RESET  = DIM_BITS'(16);
   localparam logic [DIM_BITS-1:0]   BITMAP_HEIGHT_RESET = DIM_BITS'(16);
   localparam logic [COLOR_BITS-1:0] ALPHA_KEY_RESET     = COLOR_BITS'(170);

   // Command codes carried in the request word.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef struct packed {
      logic                         cmd;
      logic signed [COORD_BITS-1:0] src_x;
      logic signed [COORD_BITS-1:0] src_y;
      logic signed [COORD_BITS-1:0] src_w;
      logic signed [COORD_BITS-1:0] src_h;
      logic signed [COORD_BITS-1:0] dst_x;
      logic signed [COORD_BITS-1:0] dst_y;
      logic                         flip_h;
      logic                         flip_v;
      logic [FADE_BITS-1:0]         fade_period;
      logic [COLOR_BITS-1:0]        fill_color;
      logic [COLOR_BITS-1:0]        pixel;
   } req_word_type;

   typedef struct packed {
      logic                  write_enable;
      logic [ADDR_BITS-1:0]  dest_address;
      logic [COLOR_BITS-1:0] write_color;
      logic [ADDR_BITS-1:0]  source_index;
      logic                  region_empty;
      logic                  region_done;
   } rsp_word_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLIP,
      ST_MUL_DY,
      ST_ACC_DY,
      ST_MUL_SH,
      ST_ACC_SH,
      ST_MUL_SY,
      ST_ACC_SY,
      ST_OUT_START,
      ST_MUL_YB,
      ST_ACC_IDX,
      ST_MUL_AREA,
      ST_CHK_IDX,
      ST_MUL_YF,
      ST_ACC_OFF,
      ST_OUT_PIXEL,
      ST_OUT_OOB,
      ST_OUT_ZERO
   } state_type;

   // Datapath operations.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLIP,
      OP_MUL_DY,
      OP_ACC_DY,
      OP_MUL_SH,
      OP_ACC_SH,
      OP_MUL_SY,
      OP_ACC_SY,
      OP_MUL_YB,
      OP_ACC_IDX,
      OP_MUL_AREA,
      OP_MUL_YF,
      OP_ACC_OFF,
      OP_OUT_START,
      OP_OUT_PIXEL,
      OP_OUT_OOB,
      OP_OUT_ZERO
   } dp_op_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic active;
      logic out_free;
      logic idx_oob;
   } dp_status_type;

endpackage

// ===== hdl/clipped_sprite_blitter_top.sv =====
// Top level of the clipped sprite blitter.
// Instantiates csb_ctrl and csb_datapath; types come from csb_pkg.
//
// Usage:
//   req_* carries one word per item. A start word (cmd 0) sets up a region:
//   translation, clipping against the frame and the source offsets; its
//   response reports region_empty. Pixel words (cmd 1) then bring source
//   pixels in raster order of the clipped region, and each response holds
//   the destination address, write enable, colour and source index.
//   csr_* writes the seven configuration registers; it is always ready and
//   is meant to be written only while no word is in flight.
//   A start word runs the clip step, the three offset products with their
//   adds and the output step. A pixel word runs the index product and add,
//   the area product, the bound check, the address product and add and the
//   output step; past the bitmap end it goes from the check to the output
//   step, and with no region open straight there. One word is worked on at
//   a time; the single shared multiplier gives each product a state of its own.
//   A finished word waits in the output register; the next word may be
//   accepted meanwhile, and only its final step waits while rsp_ready is
//   low. Reset clears the registers to their defaults, closes any region
//   and empties the output register.
module clipped_sprite_blitter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  csb_pkg::req_word_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output csb_pkg::rsp_word_type              rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [csb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [csb_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   csb_pkg::ctrl_cmd_type  ctrl_cmd;
   csb_pkg::dp_status_type dp_status;

   // Sequencer.
   csb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Arithmetic, state and output register.
   csb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ===== hdl/csb_ctrl.sv =====
// Controller of the clipped sprite blitter: sequences the clip, offset
// and per-pixel steps of the datapath. Depends on csb_pkg.
module csb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  csb_pkg::dp_status_type status,
   output csb_pkg::ctrl_cmd_type  cmd
);

   csb_pkg::state_type state_ff;
   csb_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csb_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == csb_pkg::CMD_START) begin
                  state_in = csb_pkg::ST_CLIP;
               end else if (status.active) begin
                  state_in = csb_pkg::ST_MUL_YB;
               end else begin
                  state_in = csb_pkg::ST_OUT_ZERO;
               end
            end
         end
         csb_pkg::ST_CLIP:     state_in = csb_pkg::ST_MUL_DY;
         csb_pkg::ST_MUL_DY:   state_in = csb_pkg::ST_ACC_DY;
         csb_pkg::ST_ACC_DY:   state_in = csb_pkg::ST_MUL_SH;
         csb_pkg::ST_MUL_SH:   state_in = csb_pkg::ST_ACC_SH;
         csb_pkg::ST_ACC_SH:   state_in = csb_pkg::ST_MUL_SY;
         csb_pkg::ST_MUL_SY:   state_in = csb_pkg::ST_ACC_SY;
         csb_pkg::ST_ACC_SY:   state_in = csb_pkg::ST_OUT_START;
         csb_pkg::ST_MUL_YB:   state_in = csb_pkg::ST_ACC_IDX;
         csb_pkg::ST_ACC_IDX:  state_in = csb_pkg::ST_MUL_AREA;
         csb_pkg::ST_MUL_AREA: state_in = csb_pkg::ST_CHK_IDX;
         csb_pkg::ST_CHK_IDX: begin
            if (status.idx_oob) begin
               state_in = csb_pkg::ST_OUT_OOB;
            end else begin
               state_in = csb_pkg::ST_MUL_YF;
            end
         end
         csb_pkg::ST_MUL_YF:   state_in = csb_pkg::ST_ACC_OFF;
         csb_pkg::ST_ACC_OFF:  state_in = csb_pkg::ST_OUT_PIXEL;
         csb_pkg::ST_OUT_START,
         csb_pkg::ST_OUT_PIXEL,
         csb_pkg::ST_OUT_OOB,
         csb_pkg::ST_OUT_ZERO: begin
            if (status.out_free) begin
               state_in = csb_pkg::ST_IDLE;
            end
         end
         default: state_in = csb_pkg::ST_IDLE;
      endcase
   end

   // Outputs. A result is only written once the output register is free.
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = csb_pkg::OP_NONE;
      case (state_ff)
         csb_pkg::ST_IDLE:     req_ready = 1'b1;
         csb_pkg::ST_CLIP:     cmd.op = csb_pkg::OP_CLIP;
         csb_pkg::ST_MUL_DY:   cmd.op = csb_pkg::OP_MUL_DY;
         csb_pkg::ST_ACC_DY:   cmd.op = csb_pkg::OP_ACC_DY;
         csb_pkg::ST_MUL_SH:   cmd.op = csb_pkg::OP_MUL_SH;
         csb_pkg::ST_ACC_SH:   cmd.op = csb_pkg::OP_ACC_SH;
         csb_pkg::ST_MUL_SY:   cmd.op = csb_pkg::OP_MUL_SY;
         csb_pkg::ST_ACC_SY:   cmd.op = csb_pkg::OP_ACC_SY;
         csb_pkg::ST_MUL_YB:   cmd.op = csb_pkg::OP_MUL_YB;
         csb_pkg::ST_ACC_IDX:  cmd.op = csb_pkg::OP_ACC_IDX;
         csb_pkg::ST_MUL_AREA: cmd.op = csb_pkg::OP_MUL_AREA;
         csb_pkg::ST_CHK_IDX:  cmd.op = csb_pkg::OP_NONE;
         csb_pkg::ST_MUL_YF:   cmd.op = csb_pkg::OP_MUL_YF;
         csb_pkg::ST_ACC_OFF:  cmd.op = csb_pkg::OP_ACC_OFF;
         csb_pkg::ST_OUT_START: begin
            if (status.out_free) cmd.op = csb_pkg::OP_OUT_START;
         end
         csb_pkg::ST_OUT_PIXEL: begin
            if (status.out_free) cmd.op = csb_pkg::OP_OUT_PIXEL;
         end
         csb_pkg::ST_OUT_OOB: begin
            if (status.out_free) cmd.op = csb_pkg::OP_OUT_OOB;
         end
         csb_pkg::ST_OUT_ZERO: begin
            if (status.out_free) cmd.op = csb_pkg::OP_OUT_ZERO;
         end
         default: cmd.op = csb_pkg::OP_NONE;
      endcase
      cmd.load = req_valid && req_ready;
   end

endmodule

// ===== hdl/csb_datapath.sv =====
// Datapath of the clipped sprite blitter: configuration registers, clip
// logic, one shared multiplier, region state and the output register.
// Depends on csb_pkg; driven by csb_ctrl through command and status words.
module csb_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  csb_pkg::req_word_type                     req_data,
   input  csb_pkg::ctrl_cmd_type                     cmd,
   output csb_pkg::dp_status_type                    status,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output csb_pkg::rsp_word_type                     rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [csb_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [csb_pkg::CSR_DATA_BITS-1:0]         csr_data
);

   localparam int CW = csb_pkg::CALC_BITS;
   localparam int OW = csb_pkg::OFF_BITS;
   localparam int DW = csb_pkg::DIM_BITS;
   localparam int MB = DW + 1;
   localparam int AW = csb_pkg::ADDR_BITS;
   localparam int KB = csb_pkg::COLOR_BITS;
   localparam int FB = csb_pkg::FADE_BITS;
   localparam int CB = csb_pkg::COORD_BITS;

   typedef struct packed {
      logic [DW-1:0]        fw;
      logic [DW-1:0]        fh;
      logic [DW-1:0]        bw;
      logic [DW-1:0]        bh;
      logic [KB-1:0]        key;
      logic signed [CB-1:0] tx;
      logic signed [CB-1:0] ty;
   } cfg_type;

   typedef struct packed {
      logic                 active;
      logic signed [CW-1:0] col;
      logic signed [CW-1:0] row;
      logic signed [CW-1:0] clip_w;
      logic signed [CW-1:0] clip_h;
      logic signed [OW-1:0] dest;
      logic signed [OW-1:0] src;
      logic                 flip_h;
      logic                 flip_v;
      logic [FB-1:0]        fade;
      logic                 use_pix;
      logic [FB-1:0]        fcol;
      logic [FB-1:0]        frow;
      logic [KB-1:0]        fill;
   } region_type;

   typedef struct packed {
      csb_pkg::req_word_type req;
      logic signed [CW-1:0]  dx;
      logic signed [CW-1:0]  dy;
      logic signed [CW-1:0]  sx;
      logic signed [CW-1:0]  sy;
      logic signed [CW-1:0]  sw;
      logic signed [CW-1:0]  sh;
      logic                  empty;
      logic signed [OW-1:0]  prod;
      logic signed [OW-1:0]  idx;
      logic signed [OW-1:0]  off;
   } work_type;

   cfg_type               cfg_ff, cfg_in;
   region_type            region_ff, region_in;
   work_type              work_ff, work_in;
   csb_pkg::rsp_word_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Clip terms.
   logic signed [CW-1:0] fw_s, fh_s, bw_s, bh_s;
   logic signed [CW-1:0] sx0, sy0, sw0, sh0;
   logic signed [CW-1:0] x_fit, x_shift, y_fit;
   logic signed [CW-1:0] c_sx, c_sy, c_sw, c_sh, c_dx, c_dy;
   logic                 c_empty;

   // Shared multiplier.
   logic signed [CW-1:0]    mul_a;
   logic signed [MB-1:0]    mul_b;
   logic signed [CW+MB-1:0] mul_p;

   // Offset and pixel terms.
   logic signed [OW-1:0] hf_adj, y_term, x_term;
   logic                 addr_ok, fade_on, pix_we;
   logic [KB-1:0]        pix_color;
   logic signed [CW-1:0] col_nx, row_nx;
   logic                 row_end, last_pix;
   logic [FB:0]          fcol_inc, frow_inc;
   logic [FB-1:0]        fcol_next, frow_next;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status back to the controller.
   assign status.active   = region_ff.active;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.idx_oob  = work_ff.idx[OW-1] || (work_ff.idx >= work_ff.prod);

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            csb_pkg::CSR_FRAME_WIDTH:   cfg_in.fw  = csr_data[DW-1:0];
            csb_pkg::CSR_FRAME_HEIGHT:  cfg_in.fh  = csr_data[DW-1:0];
            csb_pkg::CSR_BITMAP_WIDTH:  cfg_in.bw  = csr_data[DW-1:0];
            csb_pkg::CSR_BITMAP_HEIGHT: cfg_in.bh  = csr_data[DW-1:0];
            csb_pkg::CSR_ALPHA_KEY:     cfg_in.key = csr_data[KB-1:0];
            csb_pkg::CSR_TRANSLATE_X:   cfg_in.tx  = csr_data[CB-1:0];
            csb_pkg::CSR_TRANSLATE_Y:   cfg_in.ty  = csr_data[CB-1:0];
            default:                    cfg_in     = cfg_ff;
         endcase
      end
   end

   // Frame and bitmap sizes and the request's source fields as signed working values.
   assign fw_s = CW'(cfg_ff.fw);
   assign fh_s = CW'(cfg_ff.fh);
   assign bw_s = CW'(cfg_ff.bw);
   assign bh_s = CW'(cfg_ff.bh);
   assign sx0  = CW'(work_ff.req.src_x);
   assign sy0  = CW'(work_ff.req.src_y);
   assign sw0  = CW'(work_ff.req.src_w);
   assign sh0  = CW'(work_ff.req.src_h);

   // Clipping against the frame. Under a horizontal flip the source column
   // moves by the amount cut off the far edge of the mirror image.
   assign x_fit   = fw_s - work_ff.dx;
   assign x_shift = sx0 + sw0 - x_fit;
   assign y_fit   = fh_s - work_ff.dy;

   always_comb begin
      c_sx = sx0;
      c_sw = sw0;
      c_dx = work_ff.dx;
      if ((work_ff.dx + sw0) >= fw_s) begin
         c_sw = x_fit;
         if (work_ff.req.flip_h) c_sx = x_shift;
      end else if (work_ff.dx[CW-1]) begin
         c_sw = sw0 + work_ff.dx;
         if (!work_ff.req.flip_h) c_sx = sx0 - work_ff.dx;
         c_dx = '0;
      end
      c_sy = sy0;
      c_sh = sh0;
      c_dy = work_ff.dy;
      if ((work_ff.dy + sh0) >= fh_s) begin
         c_sh = y_fit;
      end else if (work_ff.dy[CW-1]) begin
         c_sh = sh0 + work_ff.dy;
         c_sy = sy0 - work_ff.dy;
         c_dy = '0;
      end
      c_empty = c_sw[CW-1] || (c_sw == '0) || c_sh[CW-1] || (c_sh == '0) ||
                (c_sx >= bw_s) || (c_sy >= bh_s);
   end

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         csb_pkg::OP_MUL_DY: begin
            mul_a = work_ff.dy;
            mul_b = {1'b0, cfg_ff.fw};
         end
         csb_pkg::OP_MUL_SH: begin
            mul_a = work_ff.sh - CW'(1);
            mul_b = {1'b0, cfg_ff.fw};
         end
         csb_pkg::OP_MUL_SY: begin
            mul_a = work_ff.sy;
            mul_b = {1'b0, cfg_ff.bw};
         end
         csb_pkg::OP_MUL_YB: begin
            mul_a = region_ff.row;
            mul_b = {1'b0, cfg_ff.bw};
         end
         csb_pkg::OP_MUL_AREA: begin
            mul_a = bh_s;
            mul_b = {1'b0, cfg_ff.bw};
         end
         csb_pkg::OP_MUL_YF: begin
            mul_a = region_ff.row;
            mul_b = {1'b0, cfg_ff.fw};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Offset terms for the flip directions.
   always_comb begin
      hf_adj = '0;
      if (work_ff.req.flip_h) hf_adj = OW'(work_ff.sw - CW'(1));
      y_term = work_ff.prod;
      if (region_ff.flip_v) y_term = -work_ff.prod;
      x_term = OW'(region_ff.col);
      if (region_ff.flip_h) x_term = -OW'(region_ff.col);
   end

   // Write decision and colour for one pixel.
   assign addr_ok = !work_ff.off[OW-1];
   assign fade_on = region_ff.fade != '0;
   assign pix_we  = (work_ff.req.pixel != cfg_ff.key) && addr_ok &&
                    (!fade_on || ((region_ff.fcol != '0) && (region_ff.frow != '0)));

   always_comb begin
      pix_color = '0;
      if (pix_we) begin
         if (!fade_on || region_ff.use_pix) begin
            pix_color = work_ff.req.pixel;
         end else begin
            pix_color = region_ff.fill;
         end
      end
   end

   // Raster walk and fade phases.
   assign col_nx   = region_ff.col + CW'(1);
   assign row_nx   = region_ff.row + CW'(1);
   assign row_end  = col_nx >= region_ff.clip_w;
   assign last_pix = row_end && (row_nx >= region_ff.clip_h);
   assign fcol_inc = {1'b0, region_ff.fcol} + (FB+1)'(1);
   assign frow_inc = {1'b0, region_ff.frow} + (FB+1)'(1);
   assign fcol_next = (fcol_inc == {1'b0, region_ff.fade}) ? '0 : fcol_inc[FB-1:0];
   assign frow_next = (frow_inc == {1'b0, region_ff.fade}) ? '0 : frow_inc[FB-1:0];

   // Working registers.
   always_comb begin
      work_in = work_ff;
      if (cmd.load) begin
         work_in.req = req_data;
         work_in.dx  = CW'(req_data.dst_x) + CW'(cfg_ff.tx);
         work_in.dy  = CW'(req_data.dst_y) + CW'(cfg_ff.ty);
      end
      case (cmd.op)
         csb_pkg::OP_CLIP: begin
            work_in.sx    = c_sx;
            work_in.sy    = c_sy;
            work_in.sw    = c_sw;
            work_in.sh    = c_sh;
            work_in.dx    = c_dx;
            work_in.dy    = c_dy;
            work_in.empty = c_empty;
         end
         csb_pkg::OP_MUL_DY,
         csb_pkg::OP_MUL_SH,
         csb_pkg::OP_MUL_SY,
         csb_pkg::OP_MUL_YB,
         csb_pkg::OP_MUL_AREA,
         csb_pkg::OP_MUL_YF:  work_in.prod = OW'(mul_p);
         csb_pkg::OP_ACC_IDX: work_in.idx = region_ff.src + work_ff.prod + OW'(region_ff.col);
         csb_pkg::OP_ACC_OFF: work_in.off = region_ff.dest + y_term + x_term;
         default:             work_in.prod = work_ff.prod;
      endcase
   end

   // Region state.
   always_comb begin
      region_in = region_ff;
      case (cmd.op)
         csb_pkg::OP_ACC_DY: region_in.dest = work_ff.prod + OW'(work_ff.dx) + hf_adj;
         csb_pkg::OP_ACC_SH: begin
            if (work_ff.req.flip_v) region_in.dest = region_ff.dest + work_ff.prod;
         end
         csb_pkg::OP_ACC_SY: region_in.src = work_ff.prod + OW'(work_ff.sx);
         csb_pkg::OP_OUT_START: begin
            region_in.active  = !work_ff.empty;
            region_in.col     = '0;
            region_in.row     = '0;
            region_in.clip_w  = work_ff.sw;
            region_in.clip_h  = work_ff.sh;
            region_in.flip_h  = work_ff.req.flip_h;
            region_in.flip_v  = work_ff.req.flip_v;
            region_in.fade    = work_ff.req.fade_period;
            region_in.use_pix = work_ff.req.fill_color == cfg_ff.key;
            region_in.fcol    = '0;
            region_in.frow    = '0;
            region_in.fill    = work_ff.req.fill_color;
         end
         csb_pkg::OP_OUT_OOB: region_in.active = 1'b0;
         csb_pkg::OP_OUT_PIXEL: begin
            if (row_end) begin
               region_in.col  = '0;
               region_in.fcol = '0;
               region_in.row  = row_nx;
               if (fade_on) region_in.frow = frow_next;
               if (last_pix) region_in.active = 1'b0;
            end else begin
               region_in.col = col_nx;
               if (fade_on) region_in.fcol = fcol_next;
            end
         end
         default: region_in = region_ff;
      endcase
   end

   // Output register: holds a finished word until the receiver takes it.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (cmd.op)
         csb_pkg::OP_OUT_START: begin
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            rsp_in.region_empty = work_ff.empty;
            rsp_in.region_done  = work_ff.empty;
         end
         csb_pkg::OP_OUT_ZERO: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
         end
         csb_pkg::OP_OUT_OOB: begin
            rsp_valid_in        = 1'b1;
            rsp_in              = '0;
            rsp_in.source_index = work_ff.idx[AW-1:0];
            rsp_in.region_done  = 1'b1;
         end
         csb_pkg::OP_OUT_PIXEL: begin
            rsp_valid_in        = 1'b1;
            rsp_in.write_enable = pix_we;
            rsp_in.dest_address = addr_ok ? work_ff.off[AW-1:0] : '0;
            rsp_in.write_color  = pix_color;
            rsp_in.source_index = work_ff.idx[AW-1:0];
            rsp_in.region_empty = 1'b0;
            rsp_in.region_done  = last_pix;
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fw    <= csb_pkg::FRAME_WIDTH_RESET;
         cfg_ff.fh    <= csb_pkg::FRAME_HEIGHT_RESET;
         cfg_ff.bw    <= csb_pkg::BITMAP_WIDTH_RESET;
         cfg_ff.bh    <= csb_pkg::BITMAP_HEIGHT_RESET;
         cfg_ff.key   <= csb_pkg::ALPHA_KEY_RESET;
         cfg_ff.tx    <= '0;
         cfg_ff.ty    <= '0;
         region_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== hdl/csb_checker.sv =====
// Port-level checks for the clipped sprite blitter, bound to the top level.
// Depends on csb_pkg and clipped_sprite_blitter_top.
module csb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input csb_pkg::rsp_word_type rsp_data
);

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid after reset");

   // A stalled response word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response word changed");

   // Acceptance takes the controller out of the idle state, which closes the input.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted on consecutive cycles");

   // An empty region reports done and never writes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.region_empty) |->
         (rsp_data.region_done && !rsp_data.write_enable && (rsp_data.dest_address == '0)))
      else $error("empty region word carries a write");

endmodule

bind clipped_sprite_blitter_top csb_checker u_checker (.*);
